// ----- sv/deq_pkg.sv -----
// shared types, constants and helpers for the double-ended queue
`default_nettype none
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_WALK_FWD   = 3'd4,
    OP_WALK_BWD   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_WALK
  } state_t;

  localparam ptr_t PTR_LAST = ptr_t'(DEPTH - 1);
  localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    r = (p == PTR_LAST) ? '0 : p + ptr_t'(1);
    return r;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    ptr_t r;
    r = (p == '0) ? PTR_LAST : p - ptr_t'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/double_ended_queue.sv -----
// double-ended queue: ring memory with cached front and back values
//
// Usage. One item on the slave side is one operation: s_tuser selects it
// (push front, push back, pop front, pop back, walk forward, walk
// backward) and s_tdata carries the value for a push. Results leave on
// the master side; m_tlast marks the final result of an operation and
// m_tuser carries the status (ok, pop on empty, push on full dropped).
// Timing: a push, a failed pop, a pop of the last entry and an unused code
// load the output register as they are taken; a pop that leaves entries
// behind goes through S_POP_WAIT, because the new front or back value is read
// from the ring memory (one read port) into the memory read register first.
// A walk streams one entry per cycle through the memory read register and
// the output register; a walk of an empty queue gives no result. One
// operation is in work at a time; s_tready is high when the block is idle
// and the output register is free or being taken. A stalled receiver
// holds the result and, during a walk, stops the memory reads. Reset
// empties the queue at once; the memory contents are not cleared.
`default_nettype none
module double_ended_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,  // [31:0] push_value
  input  wire logic [2:0]   s_tuser,  // [2:0] op
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,  // [31:0] out_value, [36:32] entry_count,
                                      // [68:37] front_value, [100:69] back_value, zero pad
  output logic [1:0]        m_tuser,  // [1:0] status
  output logic              m_tlast   // last_of_run
);

  deq_pkg::state_t state, state_next;

  deq_pkg::ptr_t  front_ptr, front_ptr_next;
  deq_pkg::ptr_t  back_ptr, back_ptr_next;
  deq_pkg::cnt_t  count, count_next;
  deq_pkg::data_t front_val, front_val_next;
  deq_pkg::data_t back_val, back_val_next;
  deq_pkg::data_t popped, popped_next;
  logic           pop_front, pop_front_next;

  deq_pkg::ptr_t  walk_ptr, walk_ptr_next;
  deq_pkg::cnt_t  walk_left, walk_left_next;
  logic           walk_fwd, walk_fwd_next;

  deq_pkg::data_t ring [deq_pkg::DEPTH];
  deq_pkg::data_t mem_q;
  logic           rd_valid, rd_valid_next;
  logic           rd_last, rd_last_next;

  logic           wr_en, rd_en;
  deq_pkg::ptr_t  wr_addr, rd_addr;
  deq_pkg::data_t wr_data;

  logic              accept, move, pop_read;
  deq_pkg::op_t      op;
  deq_pkg::data_t    in_val;

  logic              out_load;
  deq_pkg::data_t    out_value_next;
  deq_pkg::status_t  out_status_next;
  logic              out_last_next;

  deq_pkg::data_t    out_value, out_front, out_back;
  deq_pkg::status_t  out_status;
  deq_pkg::cnt_t     out_count;
  logic              out_last;

  assign s_tready = (state == deq_pkg::S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign op       = deq_pkg::op_t'(s_tuser);
  assign in_val   = deq_pkg::data_t'(s_tdata);
  assign move     = rd_valid && (!m_tvalid || m_tready);
  assign pop_read = accept && (op == deq_pkg::OP_POP_FRONT || op == deq_pkg::OP_POP_BACK)
                    && (count > deq_pkg::cnt_t'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::S_IDLE: begin
        if (pop_read) begin
          state_next = deq_pkg::S_POP_WAIT;
        end else if (accept && (op == deq_pkg::OP_WALK_FWD || op == deq_pkg::OP_WALK_BWD)
                     && count != '0) begin
          state_next = deq_pkg::S_WALK;
        end
      end
      deq_pkg::S_POP_WAIT: begin
        state_next = deq_pkg::S_IDLE;
      end
      deq_pkg::S_WALK: begin
        if (walk_left == '0 && !rd_valid) begin
          state_next = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    front_ptr_next  = front_ptr;
    back_ptr_next   = back_ptr;
    count_next      = count;
    front_val_next  = front_val;
    back_val_next   = back_val;
    popped_next     = popped;
    pop_front_next  = pop_front;
    walk_ptr_next   = walk_ptr;
    walk_left_next  = walk_left;
    walk_fwd_next   = walk_fwd;
    rd_valid_next   = rd_valid;
    rd_last_next    = rd_last;
    wr_en           = 1'b0;
    wr_addr         = front_ptr;
    wr_data         = in_val;
    rd_en           = 1'b0;
    rd_addr         = walk_ptr;
    out_load        = 1'b0;
    out_value_next  = '0;
    out_status_next = deq_pkg::ST_OK;
    out_last_next   = 1'b1;

    case (state)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              out_load = 1'b1;
              if (count == deq_pkg::CNT_FULL) begin
                out_status_next = deq_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + deq_pkg::cnt_t'(1);
                if (count == '0) begin
                  back_ptr_next  = front_ptr;
                  wr_addr        = front_ptr;
                  front_val_next = in_val;
                  back_val_next  = in_val;
                end else if (op == deq_pkg::OP_PUSH_FRONT) begin
                  front_ptr_next = deq_pkg::ptr_dec(front_ptr);
                  wr_addr        = deq_pkg::ptr_dec(front_ptr);
                  front_val_next = in_val;
                end else begin
                  back_ptr_next = deq_pkg::ptr_inc(back_ptr);
                  wr_addr       = deq_pkg::ptr_inc(back_ptr);
                  back_val_next = in_val;
                end
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              if (count == '0) begin
                out_load        = 1'b1;
                out_status_next = deq_pkg::ST_EMPTY;
              end else begin
                count_next     = count - deq_pkg::cnt_t'(1);
                pop_front_next = (op == deq_pkg::OP_POP_FRONT);
                popped_next    = (op == deq_pkg::OP_POP_FRONT) ? front_val : back_val;
                if (pop_read) begin
                  // new end value comes back from the ring next cycle
                  rd_en = 1'b1;
                  if (op == deq_pkg::OP_POP_FRONT) begin
                    front_ptr_next = deq_pkg::ptr_inc(front_ptr);
                    rd_addr        = deq_pkg::ptr_inc(front_ptr);
                  end else begin
                    back_ptr_next = deq_pkg::ptr_dec(back_ptr);
                    rd_addr       = deq_pkg::ptr_dec(back_ptr);
                  end
                end else begin
                  out_load       = 1'b1;
                  out_value_next = popped_next;
                end
              end
            end
            deq_pkg::OP_WALK_FWD, deq_pkg::OP_WALK_BWD: begin
              walk_fwd_next  = (op == deq_pkg::OP_WALK_FWD);
              walk_ptr_next  = (op == deq_pkg::OP_WALK_FWD) ? front_ptr : back_ptr;
              walk_left_next = count;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      deq_pkg::S_POP_WAIT: begin
        out_load       = 1'b1;
        out_value_next = popped;
        if (pop_front) begin
          front_val_next = mem_q;
        end else begin
          back_val_next = mem_q;
        end
      end
      deq_pkg::S_WALK: begin
        // memory read register and output register form a two-stage pipe
        rd_en = (walk_left != '0) && (!rd_valid || move);
        if (rd_en) begin
          walk_ptr_next  = walk_fwd ? deq_pkg::ptr_inc(walk_ptr) : deq_pkg::ptr_dec(walk_ptr);
          walk_left_next = walk_left - deq_pkg::cnt_t'(1);
          rd_last_next   = (walk_left == deq_pkg::cnt_t'(1));
          rd_valid_next  = 1'b1;
        end else if (move) begin
          rd_valid_next = 1'b0;
        end
        if (move) begin
          out_load       = 1'b1;
          out_value_next = mem_q;
          out_last_next  = rd_last;
        end
      end
      default: begin
        rd_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::S_IDLE;
      front_ptr <= '0;
      back_ptr  <= '0;
      count     <= '0;
      rd_valid  <= 1'b0;
      walk_left <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      front_ptr <= front_ptr_next;
      back_ptr  <= back_ptr_next;
      count     <= count_next;
      rd_valid  <= rd_valid_next;
      walk_left <= walk_left_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_val <= front_val_next;
    back_val  <= back_val_next;
    popped    <= popped_next;
    pop_front <= pop_front_next;
    walk_ptr  <= walk_ptr_next;
    walk_fwd  <= walk_fwd_next;
    rd_last   <= rd_last_next;
    if (out_load) begin
      out_value  <= out_value_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
      out_count  <= count_next;
      out_front  <= (count_next != '0) ? front_val_next : '0;
      out_back   <= (count_next != '0) ? back_val_next : '0;
    end
  end

  assign m_tdata = {3'b000, 32'(out_back), 32'(out_front), 5'(out_count), 32'(out_value)};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= deq_pkg::CNT_FULL)
    else $error("entry count above depth");

  a_ready_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !rd_valid)
    else $error("input taken while a walk read is in flight");

  a_pop_wait_out_free: assert property (@(posedge clk) disable iff (rst)
    state == deq_pkg::S_POP_WAIT |-> !m_tvalid)
    else $error("pop result would overwrite a waiting result");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK)
     && count != deq_pkg::CNT_FULL) |=> count == $past(count) + deq_pkg::cnt_t'(1))
    else $error("push did not raise the count");

  a_walk_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (state == deq_pkg::S_WALK && walk_left == '0 && !rd_valid) |=> state == deq_pkg::S_IDLE)
    else $error("walk did not finish");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the double-ended queue: directed table, random bursts, self-checking predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_OPS   = 170;
  localparam int HOLD_CYCLES  = 120;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    deq_pkg::data_t   value;
    deq_pkg::status_t status;
    logic             last;
    deq_pkg::cnt_t    count;
    deq_pkg::data_t   front;
    deq_pkg::data_t   back;
  } deq_result_t;

  typedef struct {
    logic [2:0]     op;
    deq_pkg::data_t value;
    int             reps;
    bit             typed;
    deq_result_t    want;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;   // [31:0] push_value
  logic [2:0]   s_tuser;   // [2:0] op
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;   // [31:0] out_value, [36:32] entry_count,
                           // [68:37] front_value, [100:69] back_value, zero pad
  logic [1:0]   m_tuser;   // [1:0] status
  logic         m_tlast;

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // shadow copy of the queue
  deq_pkg::data_t shadow_ring [deq_pkg::DEPTH];
  deq_pkg::ptr_t  head_ptr;
  deq_pkg::ptr_t  tail_ptr;
  deq_pkg::cnt_t  fill_count;

  deq_result_t pending_results[$];
  stim_row_t   stim_plan[$];

  int  fail_count    = 0;
  int  ops_sent      = 0;
  int  results_seen  = 0;
  int  full_rejects  = 0;
  int  empty_pops    = 0;
  int  longest_walk  = 0;
  bit  hold_req      = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic deq_pkg::ptr_t ring_fwd(input deq_pkg::ptr_t p);
    return (p == deq_pkg::ptr_t'(deq_pkg::DEPTH - 1)) ? '0 : p + deq_pkg::ptr_t'(1);
  endfunction

  function automatic deq_pkg::ptr_t ring_bwd(input deq_pkg::ptr_t p);
    return (p == '0) ? deq_pkg::ptr_t'(deq_pkg::DEPTH - 1) : p - deq_pkg::ptr_t'(1);
  endfunction

  function automatic void queue_result(input deq_pkg::data_t value,
                                       input deq_pkg::status_t status,
                                       input logic last);
    deq_result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    r.count  = fill_count;
    r.front  = (fill_count != 0) ? shadow_ring[head_ptr] : '0;
    r.back   = (fill_count != 0) ? shadow_ring[tail_ptr] : '0;
    pending_results.push_back(r);
  endfunction

  // advance the shadow queue by one operation and queue what it must emit
  function automatic void deq_predict(input logic [2:0] op, input deq_pkg::data_t value);
    deq_pkg::data_t popped;
    deq_pkg::ptr_t  p;
    case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (fill_count == deq_pkg::CNT_FULL) begin
          full_rejects++;
          queue_result('0, deq_pkg::ST_FULL, 1'b1);
        end else begin
          if (fill_count == 0) tail_ptr = head_ptr;
          else if (op == deq_pkg::OP_PUSH_FRONT) head_ptr = ring_bwd(head_ptr);
          else tail_ptr = ring_fwd(tail_ptr);
          shadow_ring[(op == deq_pkg::OP_PUSH_FRONT) ? head_ptr : tail_ptr] = value;
          fill_count++;
          queue_result('0, deq_pkg::ST_OK, 1'b1);
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (fill_count == 0) begin
          empty_pops++;
          queue_result('0, deq_pkg::ST_EMPTY, 1'b1);
        end else begin
          popped = shadow_ring[(op == deq_pkg::OP_POP_FRONT) ? head_ptr : tail_ptr];
          fill_count--;
          // popping the only entry leaves both pointers in place
          if (fill_count != 0) begin
            if (op == deq_pkg::OP_POP_FRONT) head_ptr = ring_fwd(head_ptr);
            else tail_ptr = ring_bwd(tail_ptr);
          end
          queue_result(popped, deq_pkg::ST_OK, 1'b1);
        end
      end
      deq_pkg::OP_WALK_FWD, deq_pkg::OP_WALK_BWD: begin
        p = (op == deq_pkg::OP_WALK_FWD) ? head_ptr : tail_ptr;
        if (fill_count > longest_walk) longest_walk = fill_count;
        for (int i = 0; i < fill_count; i++) begin
          queue_result(shadow_ring[p], deq_pkg::ST_OK, (i + 1 == fill_count));
          p = (op == deq_pkg::OP_WALK_FWD) ? ring_fwd(p) : ring_bwd(p);
        end
      end
      default: queue_result('0, deq_pkg::ST_OK, 1'b1);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic deq_pkg::data_t pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return deq_pkg::data_t'($urandom);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic add_row(input logic [2:0] op, input deq_pkg::data_t value, input int reps,
                         input bit typed, input deq_result_t want);
    stim_row_t row;
    row.op    = op;
    row.value = value;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    stim_plan.push_back(row);
  endtask

  // offer one item after an optional gap; valid stays high for a back-to-back item
  task automatic send_op(input logic [2:0] op, input deq_pkg::data_t value, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = value;
    do @(posedge clk); while (!s_tready);
    deq_predict(op, value);
    ops_sent++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, steady stretches, and one long hold-off on request
  initial begin : sink
    int stall_left;
    int steady_left;
    stall_left  = 0;
    steady_left = 0;
    m_tready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (steady_left > 0) steady_left--;
        else if ($urandom_range(0, 49) == 0) steady_left = $urandom_range(20, 60);
        else if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_out
    deq_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: out_value 0x%0h status %0d",
               m_tdata[31:0], m_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_value",   want.value,       m_tdata[31:0]);
        check_field("status",      32'(want.status), 32'(m_tuser));
        check_field("last_of_run", 32'(want.last),   32'(m_tlast));
        check_field("entry_count", 32'(want.count),  32'(m_tdata[36:32]));
        check_field("front_value", want.front,       m_tdata[68:37]);
        check_field("back_value",  want.back,        m_tdata[100:69]);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d results still expected", pending_results.size());
        $display("double_ended_queue regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    deq_result_t none;
    stim_row_t   row;
    int          n;
    int          kind;
    bit          fast;
    bit          paused;
    logic [2:0]  op;

    none     = '0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    head_ptr   = '0;
    tail_ptr   = '0;
    fill_count = '0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;

    // empty queue corner cases
    add_row(deq_pkg::OP_POP_FRONT, '0, 1, 1'b1,
            '{value: '0, status: deq_pkg::ST_EMPTY, last: 1'b1, count: '0,
              front: '0, back: '0});
    add_row(deq_pkg::OP_POP_BACK, 32'h1234_5678, 1, 1'b1,
            '{value: '0, status: deq_pkg::ST_EMPTY, last: 1'b1, count: '0,
              front: '0, back: '0});
    add_row(deq_pkg::OP_WALK_FWD, '0, 1, 1'b0, none);
    add_row(deq_pkg::OP_WALK_BWD, '0, 1, 1'b0, none);
    add_row(OP_SPARE_6, '1, 1, 1'b1,
            '{value: '0, status: deq_pkg::ST_OK, last: 1'b1, count: '0,
              front: '0, back: '0});
    // first push into empty, then drain both ends
    add_row(deq_pkg::OP_PUSH_FRONT, '1, 1, 1'b1,
            '{value: '0, status: deq_pkg::ST_OK, last: 1'b1, count: 5'd1,
              front: '1, back: '1});
    add_row(deq_pkg::OP_PUSH_BACK, '0, 1, 1'b1,
            '{value: '0, status: deq_pkg::ST_OK, last: 1'b1, count: 5'd2,
              front: '1, back: '0});
    add_row(deq_pkg::OP_POP_BACK, '0, 1, 1'b1,
            '{value: '0, status: deq_pkg::ST_OK, last: 1'b1, count: 5'd1,
              front: '1, back: '1});
    add_row(deq_pkg::OP_POP_FRONT, '0, 1, 1'b1,
            '{value: '1, status: deq_pkg::ST_OK, last: 1'b1, count: '0,
              front: '0, back: '0});
    // fill from both ends so the pointers wrap, then push into full
    add_row(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, deq_pkg::DEPTH / 2, 1'b0, none);
    add_row(deq_pkg::OP_PUSH_BACK, 32'h0000_0001, deq_pkg::DEPTH / 2, 1'b0, none);
    add_row(deq_pkg::OP_PUSH_BACK, 32'h1234_5678, 1, 1'b0, none);
    add_row(deq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff, 1, 1'b0, none);
    add_row(deq_pkg::OP_WALK_FWD, '0, 1, 1'b0, none);
    add_row(deq_pkg::OP_WALK_BWD, '0, 1, 1'b0, none);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_plan[r]) begin
      row = stim_plan[r];
      for (int i = 0; i < row.reps; i++) begin
        send_op(row.op, row.value + deq_pkg::data_t'(i), pick_gap());
        if (row.typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(row.want);
        end
      end
    end

    // sender pauses until the queue has answered everything
    @(negedge clk);
    s_tvalid = 1'b0;
    wait_drained();

    // receiver holds off while the sender keeps offering items
    hold_req = 1'b1;
    n = 0;
    paused = 1'b0;
    while (n < RANDOM_OPS) begin
      kind = $urandom_range(0, 9);
      fast = ($urandom_range(0, 3) == 0);
      if (kind <= 3) begin
        // burst of pushes, often running into full
        repeat ($urandom_range(1, 20)) begin
          op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
          send_op(op, pick_value(), fast ? 0 : pick_gap());
          n++;
        end
      end else if (kind <= 6) begin
        // burst of pops, often running past empty
        repeat ($urandom_range(1, 20)) begin
          op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
          send_op(op, pick_value(), fast ? 0 : pick_gap());
          n++;
        end
      end else if (kind == 7) begin
        op = $urandom_range(0, 1) ? deq_pkg::OP_WALK_FWD : deq_pkg::OP_WALK_BWD;
        send_op(op, pick_value(), fast ? 0 : pick_gap());
        n++;
      end else begin
        // noise over every code, spare ones included
        repeat ($urandom_range(1, 6)) begin
          op = (kind == 8) ? 3'($urandom_range(0, 7))
                           : ($urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6);
          send_op(op, pick_value(), fast ? 0 : pick_gap());
          n++;
        end
      end
      if (!paused && n >= RANDOM_OPS / 2) begin
        paused = 1'b1;
        @(negedge clk);
        s_tvalid = 1'b0;
        wait_drained();
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d operations, checked %0d results, longest walk %0d entries",
             ops_sent, results_seen, longest_walk);
    $display("saw %0d pushes into a full queue and %0d pops from an empty one",
             full_rejects, empty_pops);
    if (fail_count == 0)
      $display("double_ended_queue regression: pass");
    else
      $display("double_ended_queue regression: fail");
    $finish;
  end

endmodule

// ----- double_ended_queue.f -----
sv/deq_pkg.sv
sv/double_ended_queue.sv
tb/tb_top.sv
